@@ hdl/bpc_pkg.sv @@
// package with shared constants and register codes of the button press classifier
package bpc_pkg;

  // default geometry
  localparam int NUM_BUTTONS_DEF = 6;
  localparam int COUNT_WIDTH_DEF = 16;

  // configuration register widths
  localparam int CFG_W   = 16;
  localparam int SHIFT_W = 4;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_MIN    = 3'd0,
    REG_LONG_MIN     = 3'd1,
    REG_LONG_MAX     = 3'd2,
    REG_REPEAT_START = 3'd3,
    REG_REPEAT_SHIFT = 3'd4
  } cfg_reg_t;

  // configuration reset values
  localparam logic [CFG_W-1:0]   SHORT_MIN_RST    = 16'd2;
  localparam logic [CFG_W-1:0]   LONG_MIN_RST     = 16'd15;
  localparam logic [CFG_W-1:0]   LONG_MAX_RST     = 16'd300;
  localparam logic [CFG_W-1:0]   REPEAT_START_RST = 16'd20;
  localparam logic [SHIFT_W-1:0] REPEAT_SHIFT_RST = 4'd3;

endpackage

@@ hdl/bpc_if.sv @@
// valid/ready channel interfaces for the tick input and the event output

interface bpc_in_if #(
  parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] pin_levels;
  logic [NUM_BUTTONS-1:0] edge_flags;

  modport source (output valid, output pin_levels, output edge_flags, input ready);
  modport sink   (input valid, input pin_levels, input edge_flags, output ready);
endinterface

interface bpc_out_if #(
  parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] short_events;
  logic [NUM_BUTTONS-1:0] long_events;
  logic [NUM_BUTTONS-1:0] repeat_events;
  logic [NUM_BUTTONS-1:0] active_mask;

  modport source (output valid, output short_events, output long_events,
                  output repeat_events, output active_mask, input ready);
  modport sink   (input valid, input short_events, input long_events,
                  input repeat_events, input active_mask, output ready);
endinterface

@@ hdl/button_press_classifier.sv @@
// button press classifier: short, long and auto-repeat events per timer tick
// an accepted tick is held in stage s1, then its events in the output register
// throughput: one tick per cycle unless the output stalls; the counter row is
//   read and written back per tick, a same-edge read gets the written row
// reset: configuration to defaults, tracking and repeat state cleared, counter
//   row reads as zero until its first write back
module button_press_classifier #(
  parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = bpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bpc_in_if.sink                         in_chan,
  bpc_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]      cfg_wdata
);
  import bpc_pkg::*;

  localparam int RowW = NUM_BUTTONS * COUNT_WIDTH;
  localparam int CmpW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  // configuration registers
  logic [CFG_W-1:0]   short_min_r, long_min_r, long_max_r, repeat_start_r;
  logic [SHIFT_W-1:0] repeat_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_min_r    <= SHORT_MIN_RST;
      long_min_r     <= LONG_MIN_RST;
      long_max_r     <= LONG_MAX_RST;
      repeat_start_r <= REPEAT_START_RST;
      repeat_shift_r <= REPEAT_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SHORT_MIN:    short_min_r    <= cfg_wdata;
        REG_LONG_MIN:     long_min_r     <= cfg_wdata;
        REG_LONG_MAX:     long_max_r     <= cfg_wdata;
        REG_REPEAT_START: repeat_start_r <= cfg_wdata;
        REG_REPEAT_SHIFT: repeat_shift_r <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_r, s1_fire, in_fire;
  logic out_valid_r;

  assign s1_fire        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || s1_fire;
  assign in_fire        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  // captured tick payload
  logic [NUM_BUTTONS-1:0] s1_pins_r, s1_edges_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pins_r  <= in_chan.pin_levels;
      s1_edges_r <= in_chan.edge_flags;
    end
  end

  // hold counter memory: one row with all counters, read-modify-write per tick
  logic [RowW-1:0] cnt_mem [1];
  logic            row_valid_r;
  logic [RowW-1:0] rd_row_r;
  logic [RowW-1:0] wr_row;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      cnt_mem[0] <= wr_row;
    end
  end

  // registered read with forwarding of a write back at the same edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (s1_fire) begin
        rd_row_r <= wr_row;
      end else if (row_valid_r) begin
        rd_row_r <= cnt_mem[0];
      end else begin
        rd_row_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= 1'b0;
    end else if (s1_fire) begin
      row_valid_r <= 1'b1;
    end
  end

  // tracking and repeat state
  logic [NUM_BUTTONS-1:0] tracking_r, tracking_nxt;
  logic [NUM_BUTTONS-1:0] armed_r, armed_nxt;
  logic [NUM_BUTTONS-1:0] ev_short, ev_long, ev_rep;
  logic [COUNT_WIDTH-1:0] period_mask;

  assign period_mask = ~({COUNT_WIDTH{1'b1}} << repeat_shift_r);

  // per-button update of one tick
  always_comb begin
    logic [NUM_BUTTONS-1:0] pressed;
    logic [NUM_BUTTONS-1:0] kept;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] inc;
    logic                   at_start;
    pressed   = ~s1_pins_r;
    kept      = tracking_r;
    armed_nxt = armed_r;
    ev_short  = '0;
    ev_long   = '0;
    ev_rep    = '0;
    wr_row    = rd_row_r;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      cnt      = rd_row_r[i*COUNT_WIDTH +: COUNT_WIDTH];
      inc      = cnt + 1'b1;
      at_start = CmpW'(inc) >= CmpW'(repeat_start_r);
      if (tracking_r[i]) begin
        if (pressed[i]) begin
          wr_row[i*COUNT_WIDTH +: COUNT_WIDTH] = inc;
          armed_nxt[i] = armed_r[i] || at_start;
          ev_rep[i] = (!armed_r[i] && at_start) ||
                      (armed_nxt[i] && ((inc & period_mask) == '0));
        end else if (CmpW'(cnt) >= CmpW'(short_min_r)) begin
          ev_short[i] = CmpW'(cnt) < CmpW'(long_min_r);
          ev_long[i]  = !ev_short[i] && (CmpW'(cnt) < CmpW'(long_max_r));
          wr_row[i*COUNT_WIDTH +: COUNT_WIDTH] = '0;
          kept[i]      = 1'b0;
          armed_nxt[i] = 1'b0;
        end
      end
    end
    // edges arm after the tick is processed
    tracking_nxt = kept | s1_edges_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_r <= '0;
      armed_r    <= '0;
    end else if (s1_fire) begin
      tracking_r <= tracking_nxt;
      armed_r    <= armed_nxt;
    end
  end

  // output register
  logic [NUM_BUTTONS-1:0] short_r, long_r, rep_r, active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      short_r  <= ev_short;
      long_r   <= ev_long;
      rep_r    <= ev_rep;
      active_r <= tracking_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.short_events  = short_r;
  assign out_chan.long_events   = long_r;
  assign out_chan.repeat_events = rep_r;
  assign out_chan.active_mask   = active_r;

endmodule

@@ test/press_event_checker.sv @@
// checker that predicts and compares the button press event results
`timescale 1ns / 1ps

module press_event_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  bpc_in_if                             in_mon,
  bpc_out_if                            out_mon,
  input  logic                          cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            mismatch_count,
  output int                            pending_count
);
  import bpc_pkg::*;

  localparam int NB = NUM_BUTTONS_DEF;
  localparam int CW = COUNT_WIDTH_DEF;

  typedef struct packed {
    logic [NB-1:0] short_ev;
    logic [NB-1:0] long_ev;
    logic [NB-1:0] repeat_ev;
    logic [NB-1:0] active;
  } tick_events_t;

  // thresholds as last written
  logic [CFG_W-1:0]   short_min;
  logic [CFG_W-1:0]   long_min;
  logic [CFG_W-1:0]   long_max;
  logic [CFG_W-1:0]   rpt_start;
  logic [SHIFT_W-1:0] rpt_shift;

  // per button press state
  logic [CW-1:0] hold_count [NB];
  logic [NB-1:0] tracking;
  logic [NB-1:0] rpt_armed;

  tick_events_t expected_events [$];
  int           errors;
  int           result_index;

  // advance the press state by one tick and return the events it raises
  function automatic tick_events_t classify_tick(input logic [NB-1:0] pins,
                                                 input logic [NB-1:0] edges);
    tick_events_t  ev;
    logic [NB-1:0] held;
    logic [CW-1:0] period_mask;
    logic [CW-1:0] cnt;
    int            i;
    ev = '0;
    held = ~pins;
    period_mask = (CW'(1) << rpt_shift) - CW'(1);
    for (i = 0; i < NB; i++) begin
      if (tracking[i]) begin
        cnt = hold_count[i];
        if (held[i]) begin
          cnt = cnt + CW'(1);
          hold_count[i] = cnt;
          if (!rpt_armed[i] && cnt >= rpt_start) begin
            rpt_armed[i] = 1'b1;
            ev.repeat_ev[i] = 1'b1;
          end
          if (rpt_armed[i] && (cnt & period_mask) == '0) ev.repeat_ev[i] = 1'b1;
        end else if (cnt >= short_min) begin
          // release long enough to count as a press
          if (cnt < long_min) ev.short_ev[i] = 1'b1;
          else if (cnt < long_max) ev.long_ev[i] = 1'b1;
          hold_count[i] = '0;
          tracking[i] = 1'b0;
          rpt_armed[i] = 1'b0;
        end
      end
    end
    // edges arm only after the tick, giving the one-tick debounce
    tracking = tracking | edges;
    ev.active = tracking;
    return ev;
  endfunction

  // watch the ports, predict on each input transaction, compare on each output
  always @(posedge clk) begin
    tick_events_t exp_ev;
    tick_events_t got_ev;
    if (!rst_n) begin
      short_min = SHORT_MIN_RST;
      long_min  = LONG_MIN_RST;
      long_max  = LONG_MAX_RST;
      rpt_start = REPEAT_START_RST;
      rpt_shift = REPEAT_SHIFT_RST;
      for (int i = 0; i < NB; i++) hold_count[i] = '0;
      tracking = '0;
      rpt_armed = '0;
      expected_events.delete();
      errors = 0;
      result_index = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SHORT_MIN:    short_min = cfg_wdata;
          REG_LONG_MIN:     long_min  = cfg_wdata;
          REG_LONG_MAX:     long_max  = cfg_wdata;
          REG_REPEAT_START: rpt_start = cfg_wdata;
          REG_REPEAT_SHIFT: rpt_shift = cfg_wdata[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_events.push_back(classify_tick(in_mon.pin_levels, in_mon.edge_flags));
      if (out_mon.valid && out_mon.ready) begin
        got_ev = {out_mon.short_events, out_mon.long_events,
                  out_mon.repeat_events, out_mon.active_mask};
        if (expected_events.size() == 0) begin
          if (errors < 10) begin
            $write("result %0d arrived with no tick pending: ", result_index);
            $display("short=%h long=%h repeat=%h active=%h",
                     got_ev.short_ev, got_ev.long_ev, got_ev.repeat_ev, got_ev.active);
          end
          errors++;
        end else begin
          exp_ev = expected_events.pop_front();
          if (got_ev.short_ev !== exp_ev.short_ev || got_ev.long_ev !== exp_ev.long_ev ||
              got_ev.repeat_ev !== exp_ev.repeat_ev || got_ev.active !== exp_ev.active) begin
            if (errors < 10) begin
              $write("result %0d mismatch: expected short=%h long=%h repeat=%h active=%h, ",
                     result_index, exp_ev.short_ev, exp_ev.long_ev, exp_ev.repeat_ev,
                     exp_ev.active);
              $display("got short=%h long=%h repeat=%h active=%h",
                       got_ev.short_ev, got_ev.long_ev, got_ev.repeat_ev, got_ev.active);
            end
            errors++;
          end
        end
        result_index++;
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_events.size();
  end

endmodule

@@ test/testbench.sv @@
// top of the button press classifier testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import bpc_pkg::*;

  localparam int NB = NUM_BUTTONS_DEF;

  typedef struct {
    logic [CFG_W-1:0]   short_min;
    logic [CFG_W-1:0]   long_min;
    logic [CFG_W-1:0]   long_max;
    logic [CFG_W-1:0]   rpt_start;
    logic [SHIFT_W-1:0] rpt_shift;
  } press_cfg_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  // directed ticks as {pin_levels, edge_flags}, thresholds 2/4/6/3 and shift 1
  localparam logic [11:0] DIRECTED_TICKS [0:21] = '{
    {6'h3F, 6'h00},  // nothing tracked, nothing pressed
    {6'h00, 6'h00},  // pressed but not tracked
    {6'h00, 6'h3F},  // arm every button
    {6'h00, 6'h00},  // count one
    {6'h02, 6'h3F},  // early release keeps waiting, edge on tracked buttons
    {6'h01, 6'h00},  // short press, first repeat
    {6'h02, 6'h00},  // short press, periodic repeat
    {6'h04, 6'h00},  // long press
    {6'h08, 6'h00},  // long press
    {6'h10, 6'h00},  // release at long_max gives no event
    {6'h3F, 6'h01},  // release past long_max, re-arm button 0
    {6'h3F, 6'h00},  // release with zero count keeps waiting
    {6'h3E, 6'h00},
    {6'h3F, 6'h00},
    {6'h3E, 6'h00},
    {6'h3F, 6'h00},  // short press after a bounce
    {6'h2A, 6'h15},
    {6'h15, 6'h2A},
    {6'h00, 6'h00},
    {6'h00, 6'h00},
    {6'h3F, 6'h3F},
    {6'h3F, 6'h00}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   mismatch_count;
  int                   pending_count;

  bpc_in_if  in_chan ();
  bpc_out_if out_chan ();

  int         burst_left = 0;
  bit         sender_gapless = 1'b0;
  bit         hold_off_req = 1'b0;
  bit         hold_off_active = 1'b0;
  press_cfg_t cur_cfg;

  button_press_classifier DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  press_event_checker event_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // one long receiver hold-off, counted here while the sender keeps offering
  initial begin
    wait (hold_off_req);
    @(posedge clk);
    hold_off_active <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off_active <= 1'b0;
  end

  // receiver stalls in modes of random length
  initial begin
    stall_mode_t mode;
    int          len;
    int          phase;
    out_chan.ready <= 1'b0;
    phase = 0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 2));
      len = $urandom_range(20, 200);
      repeat (len) begin
        @(posedge clk);
        phase++;
        if (hold_off_active) begin
          out_chan.ready <= 1'b0;
        end else begin
          case (mode)
            STALL_NONE:   out_chan.ready <= 1'b1;
            STALL_RANDOM: out_chan.ready <= ($urandom_range(0, 3) != 0);
            default:      out_chan.ready <= (phase % 4 == 0);
          endcase
        end
      end
    end
  end

  // offer one tick, in bursts with random gaps between them
  task automatic send_tick(input logic [NB-1:0] pins, input logic [NB-1:0] edges);
    int gap;
    if (burst_left == 0) begin
      gap = sender_gapless ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_chan.valid      <= 1'b1;
    in_chan.pin_levels <= pins;
    in_chan.edge_flags <= edges;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // stop offering and wait for every result of the phase
  task automatic finish_phase();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // write all thresholds, plus one write to an unused index
  task automatic apply_settings(input press_cfg_t c);
    logic [CFG_IDX_W-1:0] junk_index;
    junk_index = CFG_IDX_W'(REG_REPEAT_SHIFT) + CFG_IDX_W'($urandom_range(1, 3));
    write_reg(junk_index, CFG_W'($urandom));
    write_reg(REG_SHORT_MIN, c.short_min);
    write_reg(REG_LONG_MIN, c.long_min);
    write_reg(REG_LONG_MAX, c.long_max);
    write_reg(REG_REPEAT_START, c.rpt_start);
    write_reg(REG_REPEAT_SHIFT, {(CFG_W - SHIFT_W)'($urandom), c.rpt_shift});
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_cfg = c;
  endtask

  // press sequences per button with hold times near the thresholds, plus noise
  task automatic run_random_phase(input press_cfg_t c, input int n_ticks, input int max_hold);
    int            hold_left [NB];
    int            thr;
    int            hold;
    logic [NB-1:0] pins;
    logic [NB-1:0] edges;
    apply_settings(c);
    for (int b = 0; b < NB; b++) hold_left[b] = 0;
    for (int t = 0; t < n_ticks; t++) begin
      pins = '1;
      edges = '0;
      for (int b = 0; b < NB; b++) begin
        if (hold_left[b] > 0) begin
          pins[b] = ($urandom_range(0, 63) == 0);
          hold_left[b]--;
        end else if ($urandom_range(0, 11) == 0) begin
          edges[b] = 1'b1;
          pins[b] = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 4))
            0:       thr = int'(cur_cfg.short_min);
            1:       thr = int'(cur_cfg.long_min);
            2:       thr = int'(cur_cfg.long_max);
            3:       thr = int'(cur_cfg.rpt_start);
            default: thr = $urandom_range(1, max_hold);
          endcase
          hold = thr + $urandom_range(0, 4) - 2;
          if (hold < 1 || hold > max_hold) hold = $urandom_range(1, max_hold);
          hold_left[b] = hold;
        end
      end
      if ($urandom_range(0, 31) == 0) pins = pins ^ NB'($urandom);
      if ($urandom_range(0, 31) == 0) edges = edges | NB'($urandom);
      send_tick(pins, edges);
    end
    finish_phase();
  endtask

  // stimulus and verdict
  initial begin
    press_cfg_t    c;
    logic [NB-1:0] pins;
    logic [NB-1:0] edges;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.pin_levels <= '1;
    in_chan.edge_flags <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_SHORT_MIN;
    cfg_wdata          <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks with small thresholds
    apply_settings('{16'd2, 16'd4, 16'd6, 16'd3, 4'd1});
    foreach (DIRECTED_TICKS[i]) send_tick(DIRECTED_TICKS[i][11:6], DIRECTED_TICKS[i][5:0]);
    finish_phase();

    // random phases over several threshold settings
    run_random_phase('{SHORT_MIN_RST, LONG_MIN_RST, LONG_MAX_RST, REPEAT_START_RST,
                       REPEAT_SHIFT_RST}, 300, 340);
    run_random_phase('{16'd1, 16'd1, 16'd1, 16'd1, 4'd0}, 130, 60);
    run_random_phase('{16'd10, 16'd5, 16'd3, 16'd7, 4'd2}, 130, 60);
    c.short_min = CFG_W'($urandom_range(1, 8));
    c.long_min  = CFG_W'($urandom_range(c.short_min, 40));
    c.long_max  = CFG_W'($urandom_range(c.long_min, 90));
    c.rpt_start = CFG_W'($urandom_range(1, 60));
    c.rpt_shift = SHIFT_W'($urandom_range(0, 4));
    hold_off_req = 1'b1;
    run_random_phase(c, 130, 100);
    c.short_min = CFG_W'($urandom_range(1, 40));
    c.long_min  = CFG_W'($urandom_range(1, 60));
    c.long_max  = CFG_W'($urandom_range(1, 90));
    c.rpt_start = CFG_W'($urandom_range(1, 60));
    c.rpt_shift = SHIFT_W'($urandom_range(0, 6));
    run_random_phase(c, 130, 100);
    run_random_phase('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15}, 130, 100);
    run_random_phase('{16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 4'd15}, 130, 100);
    c.short_min = CFG_W'($urandom_range(1, 65535));
    c.long_min  = CFG_W'($urandom_range(1, 65535));
    c.long_max  = CFG_W'($urandom_range(1, 65535));
    c.rpt_start = CFG_W'($urandom_range(1, 65535));
    c.rpt_shift = SHIFT_W'($urandom_range(0, 15));
    run_random_phase(c, 130, 100);

    // back to back ticks, three buttons held long, the others bounce around
    apply_settings('{16'd30, 16'd60, 16'd90, 16'd40, 4'd2});
    sender_gapless = 1'b1;
    for (int t = 0; t < 100; t++) begin
      if (t == 0) edges = '1;
      else edges = ($urandom_range(0, 15) == 0) ? NB'($urandom) : '0;
      if (t < 80) begin
        pins = '0;
        // brief release below short_min, the buttons keep waiting
        if (t == 20) pins[2:0] = '1;
        for (int b = 3; b < NB; b++) pins[b] = ($urandom_range(0, 63) == 0);
      end else begin
        pins = NB'($urandom);
      end
      send_tick(pins, edges);
    end
    sender_gapless = 1'b0;
    finish_phase();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
